// ===== sv/pktbl_pkg.sv =====
// shared types and constants of the per-key token bucket limiter
package pktbl_pkg;

    // request sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SEL,
        S_MUL1,
        S_MUL2,
        S_DIV,
        S_UPD
    } t_state;

    // one table entry as held in the entry memory
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] tokens;
        logic [31:0] last_ms;
        logic [7:0]  denials;
    } t_entry;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BURST = 8'd1;

    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // ceil(2^38 / 1875): x / 60000 is ((x >> 5) * MINUTE_RECIP) >> 38, exact for 32-bit x
    localparam logic [27:0] MINUTE_RECIP = 28'd146601551;

endpackage

// ===== sv/pktbl_div.sv =====
// divide of a 32-bit value by the milliseconds in one minute, by reciprocal multiply
module pktbl_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    import pktbl_pkg::*;

    logic        r_done;
    logic [31:0] r_quo;
    logic [54:0] n_prod;

    // 60000 = 32 * 1875: drop the power of two, then multiply by the scaled reciprocal
    always_comb begin
        n_prod = {28'd0, i_dividend[31:5]} * {27'd0, MINUTE_RECIP};
    end

    // done in the cycle after start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    // quotient register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= {15'd0, n_prod[54:38]};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== sv/per_key_token_bucket_limiter.sv =====
// per-key token bucket rate limiter over an entry memory
// A request is taken when i_start is high and o_busy is low; its single result appears
// on o_allowed and o_deny_count for exactly one cycle with o_result_valid, and must be
// captured then since the block cannot be stalled. A query ends with the select state after
// the scan, a check goes on through the multiply, divide and update states: the scan
// reads the entry memory once per entry through its single read port, then two multiply
// stages and a reciprocal multiply for the divide by one minute compute the refill. One
// request is in work at a time. Configuration writes are always taken; make them while
// no request is in work.
module per_key_token_bucket_limiter #(
    parameter int unsigned TABLE_ENTRIES   = 16,
    parameter int unsigned TOKEN_UNIT      = 1000,
    parameter logic [31:0] IDLE_TIMEOUT_MS = 32'd300000
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_command,
    input  logic [31:0]                       i_key_address,
    input  logic [31:0]                       i_now_ms,
    output logic                              o_result_valid,
    output logic                              o_allowed,
    output logic [7:0]                        o_deny_count,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pktbl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pktbl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import pktbl_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] LAST_CNT = CW'(TABLE_ENTRIES);
    localparam logic [31:0] UNIT32 = 32'(TOKEN_UNIT);

    t_state r_state, n_state;

    // configuration registers
    logic [9:0] r_rate, r_burst;

    // request registers
    logic        r_cmd;
    logic [31:0] r_key, r_now;

    // scan registers
    logic [CW-1:0]            r_cnt;
    logic                     r_pv;
    logic [IW-1:0]            r_pidx;
    logic                     r_found, r_free_found;
    logic [IW-1:0]            r_match_idx, r_free_idx, r_old_idx;
    logic [31:0]              r_oldest;
    logic [31:0]              r_m_tok, r_m_last;
    logic [7:0]               r_m_den;
    logic [TABLE_ENTRIES-1:0] r_valid, r_tmo;

    // selected entry
    logic [IW-1:0] r_e;
    logic [31:0]   r_tok, r_last;
    logic [7:0]    r_den;
    logic [31:0]   r_prod;
    logic          r_div_go;

    // result registers
    logic       r_result_valid, r_allowed;
    logic [7:0] r_deny_count;

    // entry memory
    logic [$bits(t_entry)-1:0] mem [TABLE_ENTRIES];
    logic [$bits(t_entry)-1:0] r_rd_data;
    logic                      n_rd_en, n_wr_en;
    t_entry                    rd_entry, n_wr_entry;

    logic        div_done;
    logic [31:0] div_quo;

    // update datapath
    logic [31:0] cap, sum, tok1, last1, tok2, elapsed1;
    logic [7:0]  den2;
    logic        ok;
    logic [TABLE_ENTRIES-1:0] n_valid;

    assign rd_entry = t_entry'(r_rd_data);
    assign cap      = 32'(r_burst * UNIT32);

    pktbl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_prod),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_start) n_state = S_SCAN;
            S_SCAN: if (r_cnt == LAST_CNT) n_state = S_SEL;
            S_SEL:  n_state = (r_cmd == CMD_QUERY) ? S_IDLE : S_MUL1;
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_DIV;
            S_DIV:  if (div_done) n_state = S_UPD;
            S_UPD:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_busy  = (r_state != S_IDLE);
        n_rd_en = (r_state == S_SCAN) && (r_cnt != LAST_CNT);
        n_wr_en = (r_state == S_UPD);
    end

    // refill, clamp and charge
    always_comb begin
        sum = r_tok + div_quo;
        if (div_quo != 32'd0) begin
            tok1  = (sum > cap) ? cap : sum;
            last1 = r_now;
        end else begin
            tok1  = r_tok;
            last1 = r_last;
        end
        ok       = (tok1 >= UNIT32);
        tok2     = ok ? tok1 - UNIT32 : tok1;
        den2     = ok ? 8'd0 : r_den + 8'd1;
        elapsed1 = r_now - last1;
        n_wr_entry.key     = r_key;
        n_wr_entry.tokens  = tok2;
        n_wr_entry.last_ms = last1;
        n_wr_entry.denials = den2;
    end

    // valid bits after the idle sweep, current entry by its updated last time
    always_comb begin
        n_valid      = r_valid & ~r_tmo;
        n_valid[r_e] = !(elapsed1 > IDLE_TIMEOUT_MS);
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (n_rd_en) r_rd_data <= mem[r_cnt[IW-1:0]];
        if (n_wr_en) mem[r_e] <= n_wr_entry;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_rate         <= 10'd5;
            r_burst        <= 10'd10;
            r_valid        <= '0;
            r_result_valid <= 1'b0;
            r_div_go       <= 1'b0;
            r_pv           <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_result_valid <= 1'b0;
            r_div_go       <= (r_state == S_MUL2);
            r_pv           <= n_rd_en;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_RATE)  r_rate  <= i_cfg_data;
                if (i_cfg_index == CFG_BURST) r_burst <= i_cfg_data;
            end
            if (r_state == S_SEL && r_cmd == CMD_QUERY) r_result_valid <= 1'b1;
            if (r_state == S_UPD) begin
                r_result_valid <= 1'b1;
                r_valid        <= n_valid;
            end
        end
    end

    // scan and datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cmd        <= i_command;
                r_key        <= i_key_address;
                r_now        <= i_now_ms;
                r_cnt        <= '0;
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
                r_oldest     <= i_now_ms;
                r_old_idx    <= '0;
            end
            S_SCAN: begin
                if (n_rd_en) begin
                    r_cnt <= r_cnt + CW'(1);
                end
                r_pidx <= r_cnt[IW-1:0];
                if (r_pv) begin
                    // first valid entry with the key
                    if (!r_found && r_valid[r_pidx] && rd_entry.key == r_key) begin
                        r_found     <= 1'b1;
                        r_match_idx <= r_pidx;
                        r_m_tok     <= rd_entry.tokens;
                        r_m_last    <= rd_entry.last_ms;
                        r_m_den     <= rd_entry.denials;
                    end
                    // first free entry
                    if (!r_free_found && !r_valid[r_pidx]) begin
                        r_free_found <= 1'b1;
                        r_free_idx   <= r_pidx;
                    end
                    // oldest last time below now
                    if (rd_entry.last_ms < r_oldest) begin
                        r_oldest  <= rd_entry.last_ms;
                        r_old_idx <= r_pidx;
                    end
                    // idle timeout of this entry
                    r_tmo[r_pidx] <= r_valid[r_pidx]
                                     && ((r_now - rd_entry.last_ms) > IDLE_TIMEOUT_MS);
                end
            end
            S_SEL: begin
                if (r_cmd == CMD_QUERY) begin
                    r_allowed    <= 1'b0;
                    r_deny_count <= r_found ? r_m_den : 8'd0;
                end
                if (r_found) begin
                    r_e    <= r_match_idx;
                    r_tok  <= r_m_tok;
                    r_last <= r_m_last;
                    r_den  <= r_m_den;
                end else begin
                    r_e    <= r_free_found ? r_free_idx : r_old_idx;
                    r_tok  <= cap;
                    r_last <= r_now;
                    r_den  <= 8'd0;
                end
            end
            S_MUL1: r_prod <= 32'((r_now - r_last) * r_rate);
            S_MUL2: r_prod <= 32'(r_prod * UNIT32);
            S_UPD: begin
                r_allowed    <= ok;
                r_deny_count <= (elapsed1 > IDLE_TIMEOUT_MS) ? 8'd0 : den2;
            end
            default: begin
            end
        endcase
    end

    assign o_cfg_ready    = 1'b1;
    assign o_result_valid = r_result_valid;
    assign o_allowed      = r_allowed;
    assign o_deny_count   = r_deny_count;

endmodule

// ===== sv/pktbl_chk.sv =====
// port-level checker of the per-key token bucket limiter and its bind
module pktbl_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_start,
    input logic                              o_busy,
    input logic                              i_command,
    input logic [31:0]                       i_key_address,
    input logic [31:0]                       i_now_ms,
    input logic                              o_result_valid,
    input logic                              o_allowed,
    input logic [7:0]                        o_deny_count,
    input logic                              i_cfg_valid,
    input logic                              o_cfg_ready,
    input logic [pktbl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input logic [pktbl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import pktbl_pkg::*;

    // an accepted request makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request accepted but block not busy");

    // a result comes with the return to idle
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !o_busy)
        else $error("result shown while still busy");

    // a result ends a request that was in work
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(o_busy))
        else $error("result without a request in work");

    // one strobe per request
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

endmodule

bind per_key_token_bucket_limiter pktbl_chk u_pktbl_chk (.*);

// ===== verif/per_key_token_bucket_limiter_test.sv =====
// self-checking testbench of the per-key token bucket limiter
module per_key_token_bucket_limiter_test;
    import pktbl_pkg::*;

    localparam int          N_ENTRIES   = 16;
    localparam logic [31:0] UNIT        = 32'd1000;
    localparam logic [31:0] IDLE_LIMIT  = 32'd300000;
    localparam logic [31:0] MINUTE_MS   = 32'd60000;
    localparam int          STALL_LIMIT = 2000;
    localparam int          N_RANDOM    = 150;

    typedef struct {
        logic        allowed;
        logic [7:0]  deny_count;
    } t_verdict;

    typedef struct {
        logic        cmd;
        logic [31:0] key;
        logic [31:0] now;
        logic        typed;
        logic        allowed;
        logic [7:0]  deny_count;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        i_command = CMD_CHECK;
    logic [31:0] i_key_address = '0;
    logic [31:0] i_now_ms = '0;
    logic        i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_RATE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic        o_busy;
    logic        o_result_valid;
    logic        o_allowed;
    logic [7:0]  o_deny_count;
    logic        o_cfg_ready;

    // bucket table mirror and register copies
    logic        mir_valid  [N_ENTRIES];
    logic [31:0] mir_key    [N_ENTRIES];
    logic [31:0] mir_tokens [N_ENTRIES];
    logic [31:0] mir_last   [N_ENTRIES];
    logic [7:0]  mir_denials[N_ENTRIES];
    logic [9:0]  rate_reg;
    logic [9:0]  burst_reg;

    t_verdict    verdicts[$];
    logic        row_typed = 1'b0;
    t_verdict    row_verdict = '{1'b0, 8'd0};
    int          n_req = 0;
    int          n_res = 0;
    int          n_cfg = 0;
    int          n_err = 0;
    int          n_allowed = 0;
    int          stall = 0;
    logic [31:0] now_t;
    logic [31:0] key_pool[24];
    t_row        rows[$];

    per_key_token_bucket_limiter dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // table state right after reset
    function automatic void clear_table();
        rate_reg  = 10'd5;
        burst_reg = 10'd10;
        for (int i = 0; i < N_ENTRIES; i++) begin
            mir_valid[i]   = 1'b0;
            mir_key[i]     = '0;
            mir_tokens[i]  = 32'd10 * UNIT;
            mir_last[i]    = '0;
            mir_denials[i] = '0;
        end
    endfunction

    function automatic void claim_entry(int e, logic [31:0] key, logic [31:0] now);
        mir_valid[e]   = 1'b1;
        mir_key[e]     = key;
        mir_tokens[e]  = {22'd0, burst_reg} * UNIT;
        mir_last[e]    = now;
        mir_denials[e] = '0;
    endfunction

    // charge or query one key, updating the mirror
    function automatic t_verdict charge_bucket(logic cmd, logic [31:0] key, logic [31:0] now);
        t_verdict    v;
        int          e;
        logic [31:0] elapsed;
        logic [31:0] refill;
        logic [31:0] cap;
        logic [31:0] oldest;
        e = -1;
        for (int i = 0; i < N_ENTRIES; i++)
            if (e < 0 && mir_valid[i] && mir_key[i] == key) e = i;
        if (cmd == CMD_QUERY) begin
            v.allowed    = 1'b0;
            v.deny_count = (e >= 0) ? mir_denials[e] : 8'd0;
            return v;
        end
        // free entry first, else evict the oldest below now, else entry 0
        if (e < 0) begin
            for (int i = 0; i < N_ENTRIES; i++)
                if (e < 0 && !mir_valid[i]) e = i;
            if (e < 0) begin
                oldest = now;
                e = 0;
                for (int i = 0; i < N_ENTRIES; i++)
                    if (mir_last[i] < oldest) begin
                        oldest = mir_last[i];
                        e = i;
                    end
            end
            claim_entry(e, key, now);
        end
        // refill with 32-bit wrap before the clamp
        elapsed = now - mir_last[e];
        if (elapsed != 0) begin
            refill = (elapsed * {22'd0, rate_reg} * UNIT) / MINUTE_MS;
            if (refill != 0) begin
                cap = {22'd0, burst_reg} * UNIT;
                mir_tokens[e] = mir_tokens[e] + refill;
                if (mir_tokens[e] > cap) mir_tokens[e] = cap;
                mir_last[e] = now;
            end
        end
        // idle sweep, current entry included
        for (int i = 0; i < N_ENTRIES; i++)
            if (mir_valid[i] && (now - mir_last[i]) > IDLE_LIMIT) mir_valid[i] = 1'b0;
        if (mir_tokens[e] >= UNIT) begin
            mir_tokens[e]  = mir_tokens[e] - UNIT;
            mir_denials[e] = '0;
            v.allowed = 1'b1;
        end else begin
            mir_denials[e] = mir_denials[e] + 8'd1;
            v.allowed = 1'b0;
        end
        v.deny_count = mir_valid[e] ? mir_denials[e] : 8'd0;
        return v;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch: %s got %0d expected %0d (result %0d)", what, got, want, n_res);
        n_err++;
    endtask

    // sample handshakes and results at the rising edge
    always @(posedge i_clk) begin
        t_verdict v;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_RATE) rate_reg = i_cfg_data;
                else if (i_cfg_index == CFG_BURST) burst_reg = i_cfg_data;
                n_cfg++;
            end
            if (o_result_valid) begin
                if (verdicts.size() == 0) begin
                    $display("mismatch: result %0d with no request waiting", n_res);
                    n_err++;
                end else begin
                    v = verdicts.pop_front();
                    if (o_allowed !== v.allowed) report("allowed", o_allowed, v.allowed);
                    if (o_deny_count !== v.deny_count)
                        report("deny_count", o_deny_count, v.deny_count);
                end
                n_res++;
            end
            if (i_start && !o_busy) begin
                v = charge_bucket(i_command, i_key_address, i_now_ms);
                if (v.allowed) n_allowed++;
                verdicts.push_back(row_typed ? row_verdict : v);
                n_req++;
            end
        end
    end

    // no progress watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || !i_start && !i_cfg_valid && verdicts.size() == 0 || o_result_valid
            || (i_start && !o_busy) || (i_cfg_valid && o_cfg_ready))
            stall <= 0;
        else
            stall <= stall + 1;
        if (stall >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without progress", STALL_LIMIT);
            $display("per_key_token_bucket_limiter test failed");
            $finish;
        end
    end

    // raise start with a new request and wait for it to be taken
    task automatic send_request(logic cmd, logic [31:0] key, logic [31:0] now,
                                logic typed = 1'b0, t_verdict want = '{1'b0, 8'd0});
        int c0;
        c0 = n_req;
        i_start       <= 1'b1;
        i_command     <= cmd;
        i_key_address <= key;
        i_now_ms      <= now;
        row_typed     <= typed;
        row_verdict   <= want;
        do @(negedge i_clk); while (n_req == c0);
    endtask

    // random pause between requests, mostly short
    task automatic request_gap();
        int r;
        int n;
        r = $urandom_range(0, 9);
        n = (r < 5) ? 0 : (r < 9) ? $urandom_range(1, 4) : $urandom_range(10, 60);
        if (n > 0) begin
            i_start <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        int c0;
        c0 = n_cfg;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(negedge i_clk); while (n_cfg == c0);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // let the block drain before touching registers
    task automatic drain();
        i_start <= 1'b0;
        while (verdicts.size() != 0) @(negedge i_clk);
        repeat (64) @(negedge i_clk);
    endtask

    task automatic random_requests(int count);
        int r;
        logic [31:0] key;
        for (int k = 0; k < 24; k++) key_pool[k] = $urandom;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 70) now_t = now_t + $urandom_range(0, 3000);
            else if (r < 85) now_t = now_t + $urandom_range(3000, 400000);
            else if (r < 92) now_t = $urandom;
            else now_t = now_t - $urandom_range(0, 5000);
            key = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 23)];
            send_request(($urandom_range(0, 4) == 0) ? CMD_QUERY : CMD_CHECK, key, now_t);
            request_gap();
        end
    endtask

    initial begin
        logic [9:0] rates [6];
        logic [9:0] bursts[6];
        clear_table();
        // directed rows: typed where the outcome is plain
        rows = '{
            '{CMD_QUERY, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 8'd0},
            '{CMD_CHECK, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 8'd0},
            '{CMD_QUERY, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 8'd0},
            '{CMD_CHECK, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 8'd0},
            '{CMD_CHECK, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 8'd0},
            '{CMD_CHECK, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 8'd0},
            '{CMD_CHECK, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 8'd0},
            '{CMD_CHECK, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 8'd0},
            '{CMD_CHECK, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 8'd0},
            '{CMD_CHECK, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 8'd0},
            '{CMD_CHECK, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 8'd0},
            '{CMD_CHECK, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 8'd0},
            '{CMD_CHECK, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 8'd1},
            '{CMD_QUERY, 32'hFFFF_FFFF, 32'h0000_0005, 1'b1, 1'b0, 8'd1},
            '{CMD_CHECK, 32'hFFFF_FFFF, 32'h0000_2EE0, 1'b0, 1'b0, 8'd0},
            '{CMD_CHECK, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'd0},
            '{CMD_CHECK, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'd0},
            '{CMD_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 8'd0},
            '{CMD_CHECK, 32'h8000_0000, 32'h1234_5678, 1'b0, 1'b0, 8'd0},
            '{CMD_QUERY, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0, 8'd0},
            '{CMD_CHECK, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 8'd0},
            '{CMD_CHECK, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, 8'd0}
        };
        rates  = '{10'd1000, 10'd0, 10'd1023, 10'd1, 10'd0, 10'd5};
        bursts = '{10'd1000, 10'd0, 10'd1023, 10'd1, 10'd0, 10'd10};
        rates[4]  = $urandom_range(0, 1023);
        bursts[4] = $urandom_range(0, 1023);

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[i]) begin
            send_request(rows[i].cmd, rows[i].key, rows[i].now, rows[i].typed,
                         '{rows[i].allowed, rows[i].deny_count});
            request_gap();
        end
        row_typed <= 1'b0;
        now_t = $urandom;
        random_requests(N_RANDOM);

        // one phase per register setting
        for (int p = 0; p < 6; p++) begin
            drain();
            write_reg(CFG_RATE, rates[p]);
            write_reg(CFG_BURST, bursts[p]);
            if (p == 5) write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DATA_W'($urandom));
            // empty buckets: hammer one key past the denial counter wrap
            if (p == 1)
                for (int n = 0; n < 300; n++) begin
                    send_request(CMD_CHECK, 32'h0BAD_F00D, now_t);
                    if (n % 50 == 0) request_gap();
                end
            random_requests(N_RANDOM);
        end

        drain();
        $display("covered %0d requests (%0d admitted) and %0d register writes",
                 n_req, n_allowed, n_cfg);
        $display("results checked: %0d, mismatches: %0d", n_res, n_err);
        if (n_err == 0 && verdicts.size() == 0)
            $display("per_key_token_bucket_limiter test passed");
        else
            $display("per_key_token_bucket_limiter test failed");
        $finish;
    end
endmodule
